// ===== src/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types, constants and the quarter-sine gain table of the stereo panner.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int NumSrc     = 64;
  localparam int SrcW       = 6;
  localparam int Gtd        = 256;
  localparam int TabW       = $clog2(Gtd + 1);
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_FACTOR = 3'd1,
    REG_LENGTH = 3'd2,
    REG_THRESH = 3'd3,
    REG_COMP   = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PAN, ST_READ, ST_ADOPT, ST_DIV, ST_STEP, ST_POLE,
    ST_WEIGHT, ST_ACC, ST_WB, ST_EMIT, ST_OUT
  } state_e;

  typedef struct packed {
    logic        stop;
    logic [31:0] slope;
    logic [31:0] cur;
    logic [15:0] tgt;
  } chan_t;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [31:0] mag;
    logic [12:0] dvs;
  } div_req_t;

  typedef logic [15:0] sin_tab_t [0:Gtd];

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t    t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    for (int k = 0; k <= Gtd; k++) begin
      x    = 64'(k) * HalfPiQ30 / 64'(Gtd);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      r = (sum + 64'd16384) >> 15;
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      t[k] = r[15:0];
    end
    return t;
  endfunction

  localparam sin_tab_t SinTab = build_sin_tab();

endpackage

// ===== src/stereo_pan_mixer_with_gain_smoothing.sv =====
// ----------------------------------------------------------------------------
// stereo_pan_mixer_with_gain_smoothing
// Multi-source constant-power stereo panner and mixer with gain smoothing.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis: tuser is the command (0 position update,
// 1 sample), tlast marks the last source of a frame. A frame's mixed stereo
// pair leaves on m_axis after the word carrying tlast.
// Per-source gain state sits in a synchronous memory indexed by source; each
// item reads its entry, updates it and writes it back before the next item
// is taken; a skipped sample is not written back. A sample's path depends on
// mode and stop state, each channel runs the slope divider when a buffer
// starts in linear mode, and a word with tlast passes on to the emission.
// The configuration port is always ready; the user must write it only while
// idle, the block itself does not enforce this. After reset the gains,
// accumulators and configuration hold their defaults. The result sits in an
// output register; the next input word is accepted while it waits, and the
// block holds before a second emission until the receiver takes the first.
// ----------------------------------------------------------------------------
module stereo_pan_mixer_with_gain_smoothing (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // source, has_position, direct_out, pos_x, azimuth_span, sample,
  // skip_source, first_of_buffer, zero fill
  input  logic [71:0] s_axis_tdata,
  // command
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_out, right_out
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import spm_pkg::*;

  state_e state_q, state_d;

  logic        mode_q;
  logic [15:0] factor_q;
  logic [12:0] len_q;
  logic [14:0] thr_q;
  logic [15:0] comp_q;

  logic [71:0] item_q;
  logic        last_q;
  logic        ch_q;

  chan_t [1:0] st_mem [NumSrc];
  logic [31:0] pend_mem [NumSrc];
  chan_t [1:0] st_rdata_q;
  logic [31:0] pend_rdata_q;
  logic [NumSrc-1:0] init_q, gvalid_q;

  chan_t [1:0] wk_q;
  logic [1:0][15:0] pend_q;
  logic signed [31:0] mix_q [2];
  logic signed [49:0] pprod_q;
  logic signed [56:0] wprod_q;
  logic signed [48:0] eprod_q [2];
  logic        out_valid_q;
  logic [47:0] out_data_q;

  logic [SrcW-1:0] src;
  logic            ok_sample, first, linear;
  logic [15:0]     pan_l, pan_r;
  div_req_t        div_req;
  logic            div_done;
  logic [31:0]     div_quot;

  logic [15:0]        new_tgt;
  logic signed [32:0] adiff;
  logic [31:0]        thr31;
  logic signed [33:0] lin_sum;
  logic [31:0]        lin_cur;
  logic signed [32:0] pdiff;
  logic signed [33:0] pround;
  logic signed [34:0] psum;
  logic [31:0]        pole_cur;
  logic signed [25:0] wgt;
  logic signed [32:0] acc;
  logic signed [31:0] acc_sat;
  logic signed [33:0] ev [2];
  logic [23:0]        esat [2];
  logic               accept, mem_we, pend_we, out_load;

  assign src       = item_q[SrcW-1:0];
  assign first     = item_q[65];
  assign linear    = !mode_q;
  assign ok_sample = !item_q[64] && gvalid_q[src];
  assign thr31     = {1'b0, thr_q, 16'b0};
  assign accept    = s_axis_tvalid && s_axis_tready;

  spm_pan u_pan (
    .pos_x_i (signed'(item_q[23:8])),
    .span_i  (item_q[39:24]),
    .left_o  (pan_l),
    .right_o (pan_r)
  );

  spm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Channel arithmetic on the working copy of the selected channel.
  always_comb begin
    new_tgt  = pend_q[ch_q];
    adiff    = signed'({1'b0, new_tgt, 16'b0}) - signed'({1'b0, wk_q[ch_q].cur});
    div_req.start = 1'b0;
    div_req.neg   = adiff[32];
    div_req.mag   = adiff[32] ? 32'(-adiff) : adiff[31:0];
    div_req.dvs   = len_q;
    lin_sum  = signed'({2'b0, wk_q[ch_q].cur}) + 34'(signed'(wk_q[ch_q].slope));
    if (lin_sum[33]) begin
      lin_cur = '0;
    end else if (lin_sum > 34'sh080000000) begin
      lin_cur = 32'h80000000;
    end else begin
      lin_cur = lin_sum[31:0];
    end
    pdiff  = signed'({1'b0, wk_q[ch_q].cur}) - signed'({1'b0, wk_q[ch_q].tgt, 16'b0});
    pround = 34'((pprod_q + 50'sd32768) >>> 16);
    psum   = signed'({3'b0, wk_q[ch_q].tgt, 16'b0}) + 35'(pround);
    if (psum[34]) begin
      pole_cur = '0;
    end else if (psum > 35'sh080000000) begin
      pole_cur = 32'h80000000;
    end else begin
      pole_cur = psum[31:0];
    end
    wgt = 26'((wprod_q + 57'sh040000000) >>> 31);
    acc = 33'(mix_q[ch_q]) + 33'(wgt);
    if (acc > 33'sh07FFFFFFF) begin
      acc_sat = 32'sh7FFFFFFF;
    end else if (acc < -33'sh080000000) begin
      acc_sat = -32'sh80000000;
    end else begin
      acc_sat = acc[31:0];
    end
    for (int i = 0; i < 2; i++) begin
      ev[i] = 34'((eprod_q[i] + 49'sd16384) >>> 15);
      if (ev[i] > 34'sd8388607) begin
        esat[i] = 24'h7FFFFF;
      end else if (ev[i] < -34'sd8388608) begin
        esat[i] = 24'h800000;
      end else begin
        esat[i] = ev[i][23:0];
      end
    end
    if (state_q == ST_ADOPT && first && linear) begin
      div_req.start = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = s_axis_tuser ? ST_READ : ST_PAN;
        end
      end
      ST_PAN: state_d = ST_IDLE;
      ST_READ: begin
        if (ok_sample) begin
          state_d = ST_ADOPT;
        end else if (last_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ADOPT: state_d = (first && linear) ? ST_DIV : ST_STEP;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (wk_q[ch_q].stop) begin
          state_d = ch_q ? ST_WB : ST_ADOPT;
        end else begin
          state_d = linear ? ST_WEIGHT : ST_POLE;
        end
      end
      ST_POLE: begin
        if (pole_cur < thr31 && wk_q[ch_q].tgt < {1'b0, thr_q}) begin
          state_d = ch_q ? ST_WB : ST_ADOPT;
        end else begin
          state_d = ST_WEIGHT;
        end
      end
      ST_WEIGHT: state_d = ST_ACC;
      ST_ACC:    state_d = ch_q ? ST_WB : ST_ADOPT;
      ST_WB:     state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:   state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    pend_we       = (state_q == ST_PAN) && !item_q[7];
    mem_we        = (state_q == ST_WB);
    out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      factor_q    <= 16'd65208;
      len_q       <= 13'd512;
      thr_q       <= 15'd1;
      comp_q      <= 16'd32768;
      init_q      <= '0;
      gvalid_q    <= '0;
      out_valid_q <= 1'b0;
      ch_q        <= 1'b0;
      mix_q[0]    <= '0;
      mix_q[1]    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_MODE:   mode_q   <= cfg_data_i[0];
          REG_FACTOR: factor_q <= cfg_data_i;
          REG_LENGTH: len_q    <= cfg_data_i[12:0];
          REG_THRESH: thr_q    <= cfg_data_i[14:0];
          REG_COMP:   comp_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (pend_we) begin
        gvalid_q[src] <= 1'b1;
      end
      if (mem_we) begin
        init_q[src] <= 1'b1;
      end
      if (state_q == ST_READ) begin
        ch_q <= 1'b0;
      end else if ((state_q == ST_ACC) ||
                   (state_d == ST_ADOPT && state_q != ST_READ)) begin
        ch_q <= 1'b1;
      end
      if (state_q == ST_ACC) begin
        mix_q[ch_q] <= acc_sat;
      end
      if (state_q == ST_EMIT) begin
        mix_q[0] <= '0;
        mix_q[1] <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_rdata_q   <= st_mem[s_axis_tdata[SrcW-1:0]];
    pend_rdata_q <= pend_mem[s_axis_tdata[SrcW-1:0]];
    if (pend_we) begin
      pend_mem[src] <= {pan_r, pan_l} & {32{item_q[6]}};
    end
    if (mem_we) begin
      st_mem[src] <= wk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    unique case (state_q)
      ST_READ: begin
        wk_q   <= init_q[src] ? st_rdata_q : '0;
        pend_q <= pend_rdata_q;
      end
      ST_ADOPT: begin
        if (first) begin
          wk_q[ch_q].tgt <= new_tgt;
          if (linear) begin
            wk_q[ch_q].stop <= (new_tgt < {1'b0, thr_q}) && (wk_q[ch_q].cur < thr31);
          end else begin
            wk_q[ch_q].stop <= 1'b0;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          wk_q[ch_q].slope <= div_quot;
        end
      end
      ST_STEP: begin
        if (!wk_q[ch_q].stop) begin
          if (linear) begin
            wk_q[ch_q].cur <= lin_cur;
          end else begin
            pprod_q <= 50'(pdiff) * 50'(signed'({1'b0, factor_q}));
          end
        end
      end
      ST_POLE: begin
        wk_q[ch_q].cur <= pole_cur;
        if (pole_cur < thr31 && wk_q[ch_q].tgt < {1'b0, thr_q}) begin
          wk_q[ch_q].stop <= 1'b1;
        end
      end
      ST_WEIGHT: begin
        wprod_q <= 57'(signed'(item_q[63:40])) * 57'(signed'({1'b0, wk_q[ch_q].cur}));
      end
      ST_EMIT: begin
        eprod_q[0] <= 49'(mix_q[0]) * 49'(signed'({1'b0, comp_q}));
        eprod_q[1] <= 49'(mix_q[1]) * 49'(signed'({1'b0, comp_q}));
      end
      ST_OUT: begin
        if (out_load) begin
          out_data_q <= {esat[1], esat[0]};
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/spm_div.sv =====
// ----------------------------------------------------------------------------
// spm_div
// Restoring divider, one quotient bit per cycle, for the linear gain slope.
// ----------------------------------------------------------------------------
module spm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spm_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [31:0]       quot_o
);
  import spm_pkg::*;

  logic [5:0]  cnt_q;
  logic        busy_q, neg_q;
  logic [31:0] dvd_q;
  logic [12:0] dvs_q;
  logic [13:0] rem_q;
  logic [14:0] trial;
  logic [32:0] qneg;

  assign trial = {rem_q, dvd_q[31]} - {2'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.mag;
      dvs_q <= (req_i.dvs == '0) ? 13'd1 : req_i.dvs;
      neg_q <= req_i.neg;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!trial[14]) begin
        rem_q <= trial[13:0];
        dvd_q <= {dvd_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[12:0], dvd_q[31]};
        dvd_q <= {dvd_q[30:0], 1'b0};
      end
    end
  end

  assign qneg   = 33'd0 - {1'b0, dvd_q};
  assign done_o = !busy_q && !req_i.start && (cnt_q == 6'd0);
  assign quot_o = neg_q ? qneg[31:0] : dvd_q;

endmodule

// ===== src/spm_pan.sv =====
// ----------------------------------------------------------------------------
// spm_pan
// Constant-power pan law: position and span to left and right gains.
// ----------------------------------------------------------------------------
module spm_pan (
  input  logic signed [15:0] pos_x_i,
  input  logic [15:0]        span_i,
  output logic [15:0]        left_o,
  output logic [15:0]        right_o
);
  import spm_pkg::*;

  logic [16:0]        sc;
  logic signed [33:0] prod;
  logic [33:0]        pu;
  logic [16:0]        f;
  logic [TabW+16:0]   fi;
  logic [TabW-1:0]    idx;

  always_comb begin
    sc   = 17'h10000 - {1'b0, span_i};
    prod = 34'(pos_x_i) * 34'(signed'({1'b0, sc}));
    pu   = unsigned'(prod) + 34'h080008000;
    f    = pu[32:16];
    fi   = (TabW + 17)'(f) * (TabW + 17)'(Gtd) + (TabW + 17)'(32768);
    idx  = fi[TabW+15:16];
    if (32'(idx) > Gtd) begin
      idx = TabW'(Gtd);
    end
    left_o  = SinTab[TabW'(Gtd) - idx];
    right_o = SinTab[idx];
  end

endmodule

// ===== dv/tb_stereo_pan_mixer_with_gain_smoothing.sv =====
// ----------------------------------------------------------------------------
// tb_stereo_pan_mixer_with_gain_smoothing
// Self-checking testbench for the stereo panner and mixer. A short table of
// directed words is followed by random frames under several configurations.
// Every accepted input word goes through a local model of the pan law, the
// gain smoothing and the mix. Each stereo pair that leaves the block is
// compared with the oldest predicted pair.
// ----------------------------------------------------------------------------
module tb_stereo_pan_mixer_with_gain_smoothing;
  import spm_pkg::*;

  localparam int Depth = 256;
  localparam int Limit = 3000000;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         src;
    logic               hasp;
    logic               dout;
    logic signed [15:0] x;
    logic [15:0]        span;
    logic signed [23:0] smp;
    logic               skip;
    logic               fob;
    logic               lof;
  } word_t;

  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
  } pair_t;

  typedef struct packed {
    word_t w;
    logic  typed;
    pair_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [71:0] s_data = '0;
  logic s_user = 1'b0;
  logic s_last = 1'b0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic m_ready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  stereo_pan_mixer_with_gain_smoothing dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [15:0] sin_q15 [0:Depth];
  logic        mode_q;
  logic [15:0] factor_q;
  logic [12:0] length_q;
  logic [14:0] thresh_q;
  logic [15:0] comp_q;
  logic [15:0] pend_g [0:127];
  logic [15:0] tgt_g [0:127];
  logic [31:0] cur_g [0:127];
  logic signed [31:0] slope_g [0:127];
  logic        stop_g [0:127];
  logic        src_valid [0:63];
  logic signed [31:0] mix_l, mix_r;

  pair_t pair_q [$];
  int    fails = 0;
  int    src_idle = 0;
  int    dst_idle = 0;
  int    cycles = 0;
  bit    hold_req = 0;
  int    hold_cnt = 0;

  function automatic longint rnd_shr(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic [31:0] clamp_q31(longint v);
    if (v < 0) return 32'd0;
    if (v > 64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [23:0] emit_q(logic signed [31:0] m);
    longint v;
    v = rnd_shr(longint'(m) * longint'(comp_q), 15);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a, longint b);
    longint s;
    s = longint'(a) + b;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  task automatic reset_model();
    longint unsigned x, x2, term, sum, r;
    for (int k = 0; k <= Depth; k++) begin
      x = longint'(k) * 64'd1686629713 / Depth;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      r = (sum + 16384) >> 15;
      if (r > 32768) r = 32768;
      sin_q15[k] = r[15:0];
    end
    mode_q = 0; factor_q = 16'd65208; length_q = 13'd512; thresh_q = 15'd1;
    comp_q = 16'd32768;
    for (int i = 0; i < 128; i++) begin
      pend_g[i] = 0; tgt_g[i] = 0; cur_g[i] = 0; slope_g[i] = 0; stop_g[i] = 0;
    end
    for (int i = 0; i < 64; i++) src_valid[i] = 0;
    mix_l = 0; mix_r = 0;
  endtask

  task automatic predict_mix(input word_t w, output bit emits, output pair_t res);
    int s, c;
    longint p, smp, tgt, diff, wgt, thr31, len;
    longint unsigned f, idx;
    logic [15:0] lg, rg;
    s = int'(w.src);
    emits = 0;
    res = '0;
    if (!w.cmd) begin
      if (!w.dout) begin
        lg = 16'd0; rg = 16'd0;
        if (w.hasp) begin
          p = longint'(w.x) * (65536 - longint'(w.span)) + 64'sd2147483648;
          f = (longint'(p) + 32768) >> 16;
          idx = (f * Depth + 32768) >> 16;
          if (idx > Depth) idx = Depth;
          lg = sin_q15[Depth - idx];
          rg = sin_q15[idx];
        end
        pend_g[2 * s] = lg;
        pend_g[2 * s + 1] = rg;
        src_valid[s] = 1;
      end
      return;
    end
    if (!w.skip && src_valid[s]) begin
      smp = longint'(w.smp);
      len = (length_q == 0) ? 1 : longint'(length_q);
      thr31 = longint'(thresh_q) << 16;
      for (int ch = 0; ch < 2; ch++) begin
        c = 2 * s + ch;
        if (w.fob) begin
          tgt_g[c] = pend_g[c];
          if (!mode_q) begin
            diff = (longint'(tgt_g[c]) << 16) - longint'(cur_g[c]);
            slope_g[c] = 32'(diff / len);
            stop_g[c] = (tgt_g[c] < thresh_q) && (longint'(cur_g[c]) < thr31);
          end else begin
            stop_g[c] = 0;
          end
        end
        if (stop_g[c]) continue;
        tgt = longint'(tgt_g[c]) << 16;
        if (!mode_q) begin
          cur_g[c] = clamp_q31(longint'(cur_g[c]) + longint'(slope_g[c]));
        end else begin
          diff = longint'(cur_g[c]) - tgt;
          cur_g[c] = clamp_q31(tgt + rnd_shr(diff * longint'(factor_q), 16));
          if (longint'(cur_g[c]) < thr31 && tgt_g[c] < thresh_q) begin
            stop_g[c] = 1;
            continue;
          end
        end
        wgt = rnd_shr(smp * longint'(cur_g[c]), 31);
        if (ch == 0) mix_l = sat_add(mix_l, wgt);
        else mix_r = sat_add(mix_r, wgt);
      end
    end
    if (w.lof) begin
      emits = 1;
      res.left = emit_q(mix_l);
      res.right = emit_q(mix_r);
      mix_l = 0;
      mix_r = 0;
    end
  endtask

  task automatic send_word(input word_t w, input bit typed, input pair_t typed_res);
    bit emits;
    pair_t res;
    while ($urandom_range(99) < src_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {6'd0, w.fob, w.skip, w.smp, w.span, w.x, w.dout, w.hasp, w.src};
    s_user <= w.cmd;
    s_last <= w.lof;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_mix(w, emits, res);
    if (emits) pair_q.push_back(typed ? typed_res : res);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:   mode_q = v[0];
      REG_FACTOR: factor_q = v;
      REG_LENGTH: length_q = v[12:0];
      REG_THRESH: thresh_q = v[14:0];
      REG_COMP:   comp_q = v;
      default: ;
    endcase
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pair_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic word_t pick_update(int s);
    word_t w;
    w = '0;
    w.src = 6'(s);
    w.hasp = ($urandom_range(99) < 90);
    w.dout = ($urandom_range(99) < 10);
    w.x = 16'($urandom);
    w.span = ($urandom_range(99) < 30) ? 16'd0 : 16'($urandom);
    w.smp = 24'($urandom);
    return w;
  endfunction

  function automatic int pick_src();
    return ($urandom_range(99) < 90) ? $urandom_range(7) : $urandom_range(63);
  endfunction

  task automatic run_phase(input logic md, input logic [15:0] fac, input logic [15:0] len,
                           input logic [15:0] thr, input logic [15:0] cmp,
                           input int si, input int di, input int n, input bit hold);
    int cnt, k, fpos, fper;
    word_t w;
    drain();
    write_reg(REG_MODE, {15'd0, md});
    write_reg(REG_FACTOR, fac);
    write_reg(REG_LENGTH, len);
    write_reg(REG_THRESH, thr);
    write_reg(REG_COMP, cmp);
    cfg_valid <= 1'b0;
    src_idle = si;
    dst_idle = di;
    cnt = 0;
    fpos = 0;
    fper = $urandom_range(1, 6);
    while (cnt < n) begin
      if (hold && cnt >= 20 && cnt < 25) hold_req = 1;
      if ($urandom_range(99) < 12) begin
        w = word_t'(67'({$urandom, $urandom, $urandom}));
        send_word(w, 0, '0);
        cnt++;
      end else begin
        if ($urandom_range(99) < 30) begin
          send_word(pick_update(pick_src()), 0, '0);
          cnt++;
        end
        k = $urandom_range(1, 4);
        for (int j = 0; j < k; j++) begin
          w = '0;
          w.cmd = 1;
          w.src = 6'(pick_src());
          w.x = 16'($urandom);
          w.span = 16'($urandom);
          case ($urandom_range(9))
            0: w.smp = 24'h7FFFFF;
            1: w.smp = 24'h800000;
            default: w.smp = 24'($urandom);
          endcase
          w.skip = ($urandom_range(99) < 5);
          w.fob = (fpos == 0);
          w.lof = (j == k - 1);
          send_word(w, 0, '0);
          cnt++;
        end
        fpos++;
        if (fpos >= fper) begin
          fpos = 0;
          fper = $urandom_range(1, 6);
        end
      end
    end
  endtask

  function automatic row_t mk(logic cmd, int s, logic hasp, logic dout, int x, int span,
                              int smp, logic skip, logic fob, logic lof, logic typed);
    row_t r;
    r = '0;
    r.w.cmd = cmd; r.w.src = 6'(s); r.w.hasp = hasp; r.w.dout = dout;
    r.w.x = 16'(x); r.w.span = 16'(span); r.w.smp = 24'(smp);
    r.w.skip = skip; r.w.fob = fob; r.w.lof = lof;
    r.typed = typed;
    return r;
  endfunction

  always @(posedge clk_i) begin
    pair_t exp_p, got;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      got = m_axis_tdata;
      if (pair_q.size() == 0) begin
        $error("unexpected result left_out %0d right_out %0d",
               $signed(got[23:0]), $signed(got[47:24]));
        fails++;
      end else begin
        exp_p = pair_q.pop_front();
        if (got[23:0] !== exp_p.left) begin
          $error("left_out expected %0d actual %0d", $signed(exp_p.left), $signed(got[23:0]));
          fails++;
        end
        if (got[47:24] !== exp_p.right) begin
          $error("right_out expected %0d actual %0d", $signed(exp_p.right),
                 $signed(got[47:24]));
          fails++;
        end
      end
    end
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= dst_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= Limit) begin
      $display("[stereo_pan_mixer_with_gain_smoothing] ERROR");
      $finish;
    end
  end

  row_t dir_rows [$];

  initial begin
    reset_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);
    dir_rows.push_back(mk(1, 5, 0, 0, 0, 0, 1000, 0, 1, 1, 1));
    dir_rows.push_back(mk(0, 0, 1, 0, -32768, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 1, 1, 0, 32767, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 2, 1, 0, 0, 65535, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 3, 0, 0, 12345, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 4, 1, 1, 100, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 8388607, 0, 1, 0, 0));
    dir_rows.push_back(mk(1, 1, 0, 0, 0, 0, -8388608, 0, 1, 0, 0));
    dir_rows.push_back(mk(1, 2, 0, 0, 0, 0, 8388607, 0, 1, 0, 0));
    dir_rows.push_back(mk(1, 3, 0, 0, 0, 0, 1, 0, 1, 0, 0));
    dir_rows.push_back(mk(1, 4, 0, 0, 0, 0, 5, 0, 1, 1, 0));
    dir_rows.push_back(mk(1, 6, 0, 0, 0, 0, 77, 1, 0, 1, 1));
    dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 8388607, 0, 0, 0, 0));
    dir_rows.push_back(mk(1, 1, 0, 0, 0, 0, -8388608, 0, 0, 0, 0));
    dir_rows.push_back(mk(1, 2, 0, 0, 0, 0, 8388607, 1, 0, 1, 0));
    dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 4000, 1, 1, 1, 0));
    dir_rows.push_back(mk(0, 0, 1, 0, -1, 32768, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, -1, 0, 1, 1, 0));
    dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 8388607, 0, 0, 0, 0));
    dir_rows.push_back(mk(1, 1, 0, 0, 0, 0, 8388607, 0, 0, 0, 0));
    dir_rows.push_back(mk(1, 2, 0, 0, 0, 0, 8388607, 0, 0, 1, 0));
    dir_rows.push_back(mk(1, 63, 0, 0, 0, 0, -8388608, 0, 1, 1, 0));
    src_idle = 9;
    dst_idle = 48;
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
    end
    run_phase(0, 16'd65208, 16'd4, 16'd1, 16'd32768, 9, 48, 350, 0);
    run_phase(1, 16'($urandom), 16'd16, 16'd200, 16'd20000, 9, 48, 300, 0);
    run_phase(0, 16'd0, 16'd0, 16'd32767, 16'd0, 48, 9, 150, 0);
    run_phase(1, 16'd0, 16'd1, 16'd0, 16'd32768, 48, 9, 250, 0);
    run_phase(0, 16'd65535, 16'd4096, 16'd0, 16'd32767, 0, 0, 150, 1);
    run_phase(1, 16'd65535, 16'd8, 16'd5, 16'd32768, 0, 0, 300, 0);
    drain();
    if (fails == 0) begin
      $display("[stereo_pan_mixer_with_gain_smoothing] OK");
    end else begin
      $display("[stereo_pan_mixer_with_gain_smoothing] ERROR");
    end
    $finish;
  end

endmodule

// ===== stereo_pan_mixer_with_gain_smoothing.f =====
src/spm_pkg.sv
src/spm_div.sv
src/spm_pan.sv
src/stereo_pan_mixer_with_gain_smoothing.sv
dv/tb_stereo_pan_mixer_with_gain_smoothing.sv
